### hdl/cal_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the cursor array list
// depends on nothing; used by every module of the block
package cal_pkg;

    localparam int CAP    = 32;
    localparam int DATA_W = 32;
    localparam int CUR_W  = $clog2(CAP);
    localparam int CNT_W  = $clog2(CAP + 1);
    localparam int OP_W   = 4;
    localparam int IDX_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_FIRST  = 4'd0,
        OP_LAST   = 4'd1,
        OP_PREV   = 4'd2,
        OP_NEXT   = 4'd3,
        OP_SET    = 4'd4,
        OP_INS_BF = 4'd5,
        OP_INS_AF = 4'd6,
        OP_ERASE  = 4'd7,
        OP_CLEAR  = 4'd8,
        OP_REPL   = 4'd9,
        OP_READ   = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_LAST,
        CUR_DEC,
        CUR_INC,
        CUR_INDEX
    } cur_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_ZERO
    } cnt_sel_t;

    typedef enum logic {
        ST_IDLE,
        ST_DONE
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     gap;
        logic     after;
        logic     wr;
        logic     close;
        logic     drop;
        cur_sel_t cur_sel;
        cnt_sel_t cnt_sel;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic at_first;
        logic at_last;
        logic index_ok;
    } dp_stat_t;

endpackage

### hdl/cal_ctrl.sv
`timescale 1ns / 1ps
// controller: decodes the operation into datapath commands, drives done
// depends on cal_pkg
module cal_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [cal_pkg::OP_W-1:0] op,
    input  cal_pkg::dp_stat_t       stat,
    output cal_pkg::dp_cmd_t        cmd,
    output logic                    busy,
    output logic                    done
);
    import cal_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        busy       = 1'b0;
        accept     = start && !busy;
        state_next = accept ? ST_DONE : ST_IDLE;
        done       = (state_reg == ST_DONE);

        cmd.load    = accept;
        cmd.gap     = 1'b0;
        cmd.after   = 1'b0;
        cmd.wr      = 1'b0;
        cmd.close   = 1'b0;
        cmd.drop    = 1'b0;
        cmd.cur_sel = CUR_HOLD;
        cmd.cnt_sel = CNT_HOLD;

        if (accept)
        begin
            case (op)
                OP_FIRST:
                begin
                    cmd.cur_sel = CUR_ZERO;
                end
                OP_LAST:
                begin
                    if (!stat.empty)
                        cmd.cur_sel = CUR_LAST;
                end
                OP_PREV:
                begin
                    if (!stat.at_first)
                        cmd.cur_sel = CUR_DEC;
                end
                OP_NEXT:
                begin
                    if (!stat.at_last)
                        cmd.cur_sel = CUR_INC;
                end
                OP_SET:
                begin
                    if (stat.index_ok)
                        cmd.cur_sel = CUR_INDEX;
                end
                OP_INS_BF:
                begin
                    if (stat.full)
                        cmd.drop = 1'b1;
                    else
                    begin
                        cmd.gap     = 1'b1;
                        cmd.wr      = 1'b1;
                        cmd.cnt_sel = CNT_INC;
                    end
                end
                OP_INS_AF:
                begin
                    if (stat.full)
                        cmd.drop = 1'b1;
                    else
                    begin
                        // empty list: the word lands at position zero
                        cmd.gap     = 1'b1;
                        cmd.wr      = 1'b1;
                        cmd.after   = !stat.empty;
                        cmd.cnt_sel = CNT_INC;
                        if (!stat.empty)
                            cmd.cur_sel = CUR_INC;
                    end
                end
                OP_ERASE:
                begin
                    if (!stat.empty)
                    begin
                        cmd.close   = 1'b1;
                        cmd.cnt_sel = CNT_DEC;
                        // erasing the last entry pulls the cursor back, unless it is also the first
                        if (stat.at_last && !stat.at_first)
                            cmd.cur_sel = CUR_DEC;
                    end
                end
                OP_CLEAR:
                begin
                    cmd.cur_sel = CUR_ZERO;
                    cmd.cnt_sel = CNT_ZERO;
                end
                OP_REPL:
                begin
                    if (!stat.empty)
                        cmd.wr = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

### hdl/cal_datapath.sv
`timescale 1ns / 1ps
// datapath: per-entry shift cells, cursor and count registers, result words
// depends on cal_pkg
module cal_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cal_pkg::dp_cmd_t                 cmd,
    input  logic signed [cal_pkg::DATA_W-1:0] value,
    input  logic [cal_pkg::IDX_W-1:0]        index,
    output cal_pkg::dp_stat_t                stat,
    output logic signed [cal_pkg::DATA_W-1:0] element,
    output logic [cal_pkg::CUR_W-1:0]        cursor,
    output logic [cal_pkg::CNT_W-1:0]        count,
    output logic                             is_empty,
    output logic                             dropped
);
    import cal_pkg::*;

    logic signed [DATA_W-1:0] entries_reg [CAP];
    logic signed [DATA_W-1:0] entries_next [CAP];
    logic [CUR_W-1:0]         cursor_reg;
    logic [CUR_W-1:0]         cursor_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     dropped_reg;
    logic [CNT_W-1:0]         cur_ext;
    logic [CNT_W-1:0]         wpos;

    assign cur_ext = CNT_W'(cursor_reg);
    assign wpos    = cur_ext + CNT_W'(cmd.after);

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg >= CNT_W'(CAP));
    assign stat.at_first = (cursor_reg == '0);
    assign stat.at_last  = ((cur_ext + CNT_W'(1)) >= count_reg);
    assign stat.index_ok = (CNT_W'(index) < count_reg);

    for (genvar g = 0; g < CAP; g++)
    begin : g_cell
        localparam logic [CNT_W-1:0] POS = CNT_W'(g);
        logic signed [DATA_W-1:0] below;
        logic signed [DATA_W-1:0] above;

        if (g == 0)
        begin : g_lo
            assign below = entries_reg[g];
        end
        else
        begin : g_lo
            assign below = entries_reg[g-1];
        end

        if (g == CAP - 1)
        begin : g_hi
            assign above = entries_reg[g];
        end
        else
        begin : g_hi
            assign above = entries_reg[g+1];
        end

        always_comb
        begin
            entries_next[g] = entries_reg[g];
            if (cmd.gap && (POS > wpos))
                entries_next[g] = below;
            if (cmd.close && (POS >= cur_ext))
                entries_next[g] = above;
            if (cmd.wr && (POS == wpos))
                entries_next[g] = value;
        end
    end

    always_comb
    begin
        case (cmd.cur_sel)
            CUR_ZERO:  cursor_next = '0;
            CUR_LAST:  cursor_next = CUR_W'(count_reg - CNT_W'(1));
            CUR_DEC:   cursor_next = cursor_reg - CUR_W'(1);
            CUR_INC:   cursor_next = cursor_reg + CUR_W'(1);
            CUR_INDEX: cursor_next = CUR_W'(index);
            default:   cursor_next = cursor_reg;
        endcase

        case (cmd.cnt_sel)
            CNT_INC:  count_next = count_reg + CNT_W'(1);
            CNT_DEC:  count_next = count_reg - CNT_W'(1);
            CNT_ZERO: count_next = '0;
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg  <= '0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            cursor_reg  <= cursor_next;
            count_reg   <= count_next;
            dropped_reg <= cmd.drop;
        end
    end

    assign element  = stat.empty ? '0 : entries_reg[cursor_reg];
    assign cursor   = cursor_reg;
    assign count    = count_reg;
    assign is_empty = stat.empty;
    assign dropped  = dropped_reg;

endmodule

### hdl/cursor_array_list.sv
`timescale 1ns / 1ps
// cursor array list: fixed-capacity ordered list of signed words with a cursor
// latency: result word on the cycle after start is taken, done high one cycle
// throughput: one operation per cycle, busy stays low; inserts and erases move
// the entries from the cursor position on at once through one shift cell per entry
// reset: asynchronous active-low, list empty, cursor zero; entries not cleared
// the receiver cannot stall; done marks each result for one cycle only
module cursor_array_list (
    input  logic                             clk,
    input  logic                             rst_n,
    // command side
    input  logic                             start,
    output logic                             busy,
    input  logic [cal_pkg::OP_W-1:0]         op,
    input  logic signed [cal_pkg::DATA_W-1:0] value,
    input  logic [cal_pkg::IDX_W-1:0]        index,
    // result side
    output logic                             done,
    output logic signed [cal_pkg::DATA_W-1:0] element,
    output logic [cal_pkg::CUR_W-1:0]        cursor,
    output logic [cal_pkg::CNT_W-1:0]        count,
    output logic                             is_empty,
    output logic                             dropped
);
    import cal_pkg::*;

    // command and status between controller and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller: op decode against list status, done strobe
    cal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // datapath: entry cells plus cursor and count; result fields read
    // straight from the registers, which hold the state after the last step
    cal_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .value    (value),
        .index    (index),
        .stat     (stat),
        .element  (element),
        .cursor   (cursor),
        .count    (count),
        .is_empty (is_empty),
        .dropped  (dropped)
    );

endmodule

### hdl/cal_checker.sv
`timescale 1ns / 1ps
// port-level checks for the cursor array list, bound to the top level
// depends on cal_pkg
module cal_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [cal_pkg::CUR_W-1:0]         cursor,
    input logic [cal_pkg::CNT_W-1:0]         count,
    input logic                              is_empty,
    input logic                              dropped
);
    import cal_pkg::*;

    // every accepted word gives one result on the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("no result after accepted word");

    // no result without an accepted word
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without accepted word");

    // cursor stays inside the list
    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((CNT_W'(cursor) < count) || (cursor == '0 && count == '0)))
        else $error("cursor outside list");

    // a refused insert only happens on a full list, which it leaves full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped) |-> (count == CNT_W'(CAP) && !is_empty))
        else $error("insert refused on a list that was not full");

    // count moves by at most one per result, unless the result leaves it zero
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && count != '0) |->
            ((count == $past(count)) || (count == $past(count) + CNT_W'(1))
             || (count + CNT_W'(1) == $past(count)))
        )
        else $error("count jumped");

endmodule

bind cursor_array_list cal_checker u_cal_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .cursor   (cursor),
    .count    (count),
    .is_empty (is_empty),
    .dropped  (dropped)
);
